[design/rqpf_pkg.sv]
// Package for the ring queue with push-front: sizes, operation and status codes,
// and the control word carried between the pipeline registers.
// No dependencies; the interfaces and the core refer to it by scoped names.
package rqpf_pkg;

  // Built ring depth and the fixed field widths of the channel words.
  localparam int unsigned DEPTH          = 64;
  localparam int unsigned POS_W          = 6;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned ST_W           = 2;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes; codes five to seven are no-ops.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Control fields of one result, held while the slot read is in flight.
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] next_pos;
    logic             at_tail;
    logic [POS_W-1:0] head;
    logic [POS_W-1:0] tail;
    logic             use_rdata;
  } res_ctrl_t;

endpackage

[design/rqpf_op_if.sv]
// Operation channel of the ring queue: valid/ready handshake and one operation word.
// Depends on rqpf_pkg for the field widths.
interface rqpf_op_if #(
  parameter int unsigned DATA_WIDTH = rqpf_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [rqpf_pkg::OP_W-1:0]     operation;
  logic [DATA_WIDTH-1:0]         item;
  logic [rqpf_pkg::POS_W-1:0]    position;

  modport source (output valid, output operation, output item, output position,
                  input ready);
  modport sink   (input valid, input operation, input item, input position,
                  output ready);
endinterface

[design/rqpf_res_if.sv]
// Result channel of the ring queue: valid/ready handshake and one result word.
// Depends on rqpf_pkg for the field widths.
interface rqpf_res_if #(
  parameter int unsigned DATA_WIDTH = rqpf_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [rqpf_pkg::ST_W-1:0]     status;
  logic [rqpf_pkg::CNT_W-1:0]    count_after;
  logic [DATA_WIDTH-1:0]         item_out;
  logic [rqpf_pkg::POS_W-1:0]    next_position;
  logic                          reached_tail;
  logic [rqpf_pkg::POS_W-1:0]    head_position;
  logic [rqpf_pkg::POS_W-1:0]    tail_position;

  modport source (output valid, output status, output count_after, output item_out,
                  output next_position, output reached_tail, output head_position,
                  output tail_position, input ready);
  modport sink   (input valid, input status, input count_after, input item_out,
                  input next_position, input reached_tail, input head_position,
                  input tail_position, output ready);
endinterface

[design/rqpf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rqpf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ring_queue_with_push_front_core.sv]
// Ring queue with push-front: append, insert at head, remove, read at position, clear.
// Each accepted word passes through the control register, then the result register; one word
// can be accepted every cycle while the result register is not stalled, set by the slot RAM port.
// Reset (rst_ni low) empties the queue and sets capacity to the built depth of 64.
// Slot contents are not cleared; only occupied slots are ever read.
// Depends on rqpf_pkg, rqpf_op_if, rqpf_res_if and rqpf_ram.
module ring_queue_with_push_front_core #(
  parameter int unsigned DATA_WIDTH = rqpf_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rqpf_pkg::CNT_W-1:0] cfg_wdata_i,
  rqpf_op_if.sink                    op_i,
  rqpf_res_if.source                 res_o
);

  localparam int unsigned POS_W = rqpf_pkg::POS_W;
  localparam int unsigned CNT_W = rqpf_pkg::CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rqpf_pkg::DEPTH);

  // Queue state.
  logic [CNT_W-1:0] cap_q;
  logic [POS_W-1:0] head_q, head_d;
  logic [POS_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pipeline registers: control word waiting for slot data, then the result word.
  rqpf_pkg::res_ctrl_t s1_q, s1_d;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic [rqpf_pkg::ST_W-1:0] out_status_q;
  logic [CNT_W-1:0]    out_count_q;
  logic [DATA_WIDTH-1:0] out_item_q;
  logic [POS_W-1:0]    out_next_q;
  logic                out_at_tail_q;
  logic [POS_W-1:0]    out_head_q;
  logic [POS_W-1:0]    out_tail_q;

  // Slot RAM ports.
  logic                  ram_we, ram_re;
  logic [POS_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic accept, out_free, s1_adv;
  logic [CNT_W-1:0] cfg_cap;

  // Slot after p, wrapped at the current capacity.
  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + CNT_W'(1);
    return (n >= cap) ? '0 : n[POS_W-1:0];
  endfunction

  // Handshake: the result register frees when empty or taken.
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign op_i.ready  = !s1_valid_q || out_free;
  assign accept      = op_i.valid && op_i.ready;

  // Capacity write value: saturated to the built depth.
  assign cfg_cap = (cfg_wdata_i > DEPTH_C) ? DEPTH_C : cfg_wdata_i;

  // Operation decode and next pointer state.
  always_comb begin
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W:0]   off, off_w;
    logic [POS_W-1:0] ins_head;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_waddr = tail_q;
    ram_raddr = head_q;
    s1_d.status    = rqpf_pkg::ST_OK;
    s1_d.next_pos  = '0;
    s1_d.at_tail   = 1'b0;
    s1_d.use_rdata = 1'b0;
    pos_ext  = {1'b0, op_i.position};
    off      = {2'b00, op_i.position} + {1'b0, cap_q} - {2'b00, head_q};
    off_w    = (off >= {1'b0, cap_q}) ? off - {1'b0, cap_q} : off;
    ins_head = (head_q == '0) ? POS_W'(cap_q - CNT_W'(1)) : head_q - POS_W'(1);
    case (rqpf_pkg::op_e'(op_i.operation))
      rqpf_pkg::OP_APPEND: begin
        if (count_q >= cap_q) begin
          s1_d.status = rqpf_pkg::ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tail_q;
          tail_d    = wrap_inc(tail_q, cap_q);
          count_d   = count_q + CNT_W'(1);
        end
      end
      rqpf_pkg::OP_INSERT: begin
        if (count_q >= cap_q) begin
          s1_d.status = rqpf_pkg::ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ins_head;
          head_d    = ins_head;
          count_d   = count_q + CNT_W'(1);
        end
      end
      rqpf_pkg::OP_REMOVE: begin
        if (count_q == '0) begin
          s1_d.status = rqpf_pkg::ST_EMPTY;
        end else begin
          ram_re         = 1'b1;
          ram_raddr      = head_q;
          s1_d.use_rdata = 1'b1;
          head_d         = wrap_inc(head_q, cap_q);
          count_d        = count_q - CNT_W'(1);
        end
      end
      rqpf_pkg::OP_READ: begin
        if (pos_ext >= cap_q || off_w >= {1'b0, count_q}) begin
          s1_d.status = rqpf_pkg::ST_BADPOS;
        end else begin
          ram_re         = 1'b1;
          ram_raddr      = op_i.position;
          s1_d.use_rdata = 1'b1;
          s1_d.next_pos  = wrap_inc(op_i.position, cap_q);
          s1_d.at_tail   = (wrap_inc(op_i.position, cap_q) == tail_q);
        end
      end
      rqpf_pkg::OP_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    s1_d.count = count_d;
    s1_d.head  = head_d;
    s1_d.tail  = tail_d;
    ram_we = ram_we && accept;
    ram_re = ram_re && accept;
  end

  // Slot store.
  rqpf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (rqpf_pkg::DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_i.item),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Capacity register and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= DEPTH_C;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i != '0 && cfg_cap != cap_q) begin
        cap_q   <= cfg_cap;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end
    end else if (accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload: the control word, then the result word with slot data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_status_q  <= s1_q.status;
      out_count_q   <= s1_q.count;
      out_item_q    <= s1_q.use_rdata ? ram_rdata : '0;
      out_next_q    <= s1_q.next_pos;
      out_at_tail_q <= s1_q.at_tail;
      out_head_q    <= s1_q.head;
      out_tail_q    <= s1_q.tail;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.count_after   = out_count_q;
  assign res_o.item_out      = out_item_q;
  assign res_o.next_position = out_next_q;
  assign res_o.reached_tail  = out_at_tail_q;
  assign res_o.head_position = out_head_q;
  assign res_o.tail_position = out_tail_q;

  // Ring distance from head to tail, used to cross-check the entry count.
  logic [CNT_W:0] ring_dist;
  assign ring_dist = ({2'b00, tail_q} + {1'b0, cap_q} - {2'b00, head_q} >= {1'b0, cap_q}) ?
                     ({2'b00, tail_q} - {2'b00, head_q}) :
                     ({2'b00, tail_q} + {1'b0, cap_q} - {2'b00, head_q});

  // The count never exceeds the capacity and both pointers stay inside the ring.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q && {1'b0, head_q} < cap_q && {1'b0, tail_q} < cap_q)
    else $error("queue pointer or count outside capacity");

  // Head-to-tail distance matches the count, with a full ring showing distance zero.
  a_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_dist == ((count_q == cap_q) ? '0 : {1'b0, count_q}))
    else $error("head/tail distance disagrees with entry count");

  // A refused append or insert on a full queue leaves the pointers alone.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && count_q >= cap_q &&
     (op_i.operation == rqpf_pkg::OP_APPEND || op_i.operation == rqpf_pkg::OP_INSERT))
    |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)))
    else $error("full queue changed on a refused write");

  // A waiting control word holds steady while the result register is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_q)))
    else $error("control word lost while result register stalled");

endmodule

[sim/tb_ring_queue_with_push_front_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ring_queue_with_push_front_core: random operation traffic
// with bursty sending and a stalling receiver, results scored against a built-in ring model.
// Depends on rqpf_pkg, rqpf_op_if, rqpf_res_if and the core itself.
module tb_ring_queue_with_push_front_core;

  localparam int unsigned DW          = rqpf_pkg::DATA_WIDTH_DEF;
  localparam int unsigned OP_W        = rqpf_pkg::OP_W;
  localparam int unsigned POS_W       = rqpf_pkg::POS_W;
  localparam int unsigned CNT_W       = rqpf_pkg::CNT_W;
  localparam int unsigned DEPTH       = rqpf_pkg::DEPTH;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 40;

  // Operation codes without a function; the core treats them as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [DW-1:0]    item;
    logic [POS_W-1:0] pos;
  } queue_cmd_t;

  typedef struct {
    rqpf_pkg::status_e status;
    logic [CNT_W-1:0] count;
    logic [DW-1:0]    data;
    logic [POS_W-1:0] next_pos;
    logic             at_tail;
    logic [POS_W-1:0] head;
    logic [POS_W-1:0] tail;
  } queue_reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  rqpf_op_if  #(.DATA_WIDTH(DW)) op_bus ();
  rqpf_res_if #(.DATA_WIDTH(DW)) res_bus ();

  ring_queue_with_push_front_core #(.DATA_WIDTH(DW)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_bus),
    .res_o       (res_bus)
  );

  // Words waiting to be sent and replies waiting to come back.
  queue_cmd_t   pending_ops[$];
  queue_reply_t expected_replies[$];

  bit          op_pending;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned send_burst;
  logic [15:0] ready_mask;
  logic [3:0]  ready_phase;

  // Shadow copy of the ring: slots, pointers, fill level and capacity.
  logic [DW-1:0] ring_slots [DEPTH];
  int unsigned   ring_head;
  int unsigned   ring_tail;
  int unsigned   ring_count;
  int unsigned   ring_cap;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned ring_step(int unsigned p);
    return (p + 1 >= ring_cap) ? 0 : p + 1;
  endfunction

  function automatic void ring_reset();
    foreach (ring_slots[i]) ring_slots[i] = '0;
    ring_cap   = DEPTH;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
  endfunction

  // Zero is ignored, large values saturate, and a real change empties the ring.
  function automatic void ring_configure(int unsigned value);
    int unsigned c;
    value = value & 32'h7f;
    if (value == 0) return;
    c = (value > DEPTH) ? DEPTH : value;
    if (c == ring_cap) return;
    ring_cap   = c;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
  endfunction

  // Applies one accepted word to the shadow ring and returns the reply it should produce.
  function automatic queue_reply_t ring_apply(queue_cmd_t c);
    queue_reply_t r;
    int unsigned  offs;
    int unsigned  pos_u;
    pos_u      = 32'(c.pos);
    r.status   = rqpf_pkg::ST_OK;
    r.data     = '0;
    r.next_pos = '0;
    r.at_tail  = 1'b0;
    case (c.op)
      rqpf_pkg::OP_APPEND: begin
        if (ring_count >= ring_cap) begin
          r.status = rqpf_pkg::ST_FULL;
        end else begin
          ring_slots[ring_tail] = c.item;
          ring_tail = ring_step(ring_tail);
          ring_count++;
        end
      end
      rqpf_pkg::OP_INSERT: begin
        if (ring_count >= ring_cap) begin
          r.status = rqpf_pkg::ST_FULL;
        end else begin
          ring_head = (ring_head == 0) ? ring_cap - 1 : ring_head - 1;
          ring_slots[ring_head] = c.item;
          ring_count++;
        end
      end
      rqpf_pkg::OP_REMOVE: begin
        if (ring_count == 0) begin
          r.status = rqpf_pkg::ST_EMPTY;
        end else begin
          r.data = ring_slots[ring_head];
          ring_head = ring_step(ring_head);
          ring_count--;
        end
      end
      rqpf_pkg::OP_READ: begin
        offs = (pos_u + ring_cap - ring_head) % ring_cap;
        if (pos_u >= ring_cap || offs >= ring_count) begin
          r.status = rqpf_pkg::ST_BADPOS;
        end else begin
          r.data     = ring_slots[pos_u];
          r.next_pos = POS_W'(ring_step(pos_u));
          r.at_tail  = (ring_step(pos_u) == ring_tail);
        end
      end
      rqpf_pkg::OP_CLEAR: begin
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(ring_count);
    r.head  = POS_W'(ring_head);
    r.tail  = POS_W'(ring_tail);
    return r;
  endfunction

  task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (want !== got) begin
      if (error_count < REPORT_MAX)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic post_op(logic [OP_W-1:0] op, logic [DW-1:0] item, int unsigned pos);
    queue_cmd_t c;
    c.op   = op;
    c.item = item;
    c.pos  = POS_W'(pos);
    pending_ops.push_back(c);
  endtask

  // Blocks until every queued word has been sent and every reply has come back.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_replies.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_capacity(int unsigned value);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ring_configure(value);
  endtask

  // Random traffic in segments: fills, drains, mixed reads, walks from the head,
  // noise with spare codes and wild positions, and clears.
  task automatic run_traffic(int unsigned budget);
    int unsigned issued;
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    logic [OP_W-1:0] op;
    issued = 0;
    while (issued < budget) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        len = $urandom_range(1, ring_cap + 2);
        for (int i = 0; i < len; i++)
          post_op(($urandom_range(0, 3) == 0) ? rqpf_pkg::OP_INSERT : rqpf_pkg::OP_APPEND,
                  $urandom(), $urandom_range(0, 63));
        issued += len;
      end else if (kind <= 4) begin
        len = $urandom_range(1, ring_cap + 2);
        for (int i = 0; i < len; i++)
          post_op(rqpf_pkg::OP_REMOVE, $urandom(), $urandom_range(0, 63));
        issued += len;
      end else if (kind <= 6) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6)
            post_op(rqpf_pkg::OP_READ, $urandom(), $urandom_range(0, ring_cap - 1));
          else if (pick == 6) post_op(rqpf_pkg::OP_APPEND, $urandom(), $urandom_range(0, 63));
          else if (pick == 7) post_op(rqpf_pkg::OP_INSERT, $urandom(), $urandom_range(0, 63));
          else if (pick == 8) post_op(rqpf_pkg::OP_REMOVE, $urandom(), $urandom_range(0, 63));
          else                post_op(rqpf_pkg::OP_READ, $urandom(), $urandom_range(0, 63));
        end
        issued += len;
      end else if (kind == 7) begin
        // Walk up to 24 slots from the head: the occupied ones and the tail slot just past them.
        wait_drained();
        len = (ring_count + 1 > 24) ? 24 : ring_count + 1;
        for (int i = 0; i < len; i++)
          post_op(rqpf_pkg::OP_READ, $urandom(), (ring_head + i) % ring_cap);
        issued += len;
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          op = OP_W'($urandom_range(0, OP_SPARE_LAST));
          post_op(op, $urandom(), $urandom_range(0, 63));
          if (op <= rqpf_pkg::OP_CLEAR) issued++;
        end
      end else begin
        post_op(rqpf_pkg::OP_CLEAR, $urandom(), $urandom_range(0, 63));
        issued++;
      end
    end
  endtask

  // Driver: sends words in bursts with gaps and drives the receiver's stall pattern.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!op_pending) begin
        if (send_gap > 0) begin
          send_gap--;
          op_bus.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op_bus.valid     <= 1'b1;
          op_bus.operation <= pending_ops[0].op;
          op_bus.item      <= pending_ops[0].item;
          op_bus.position  <= pending_ops[0].pos;
          op_pending = 1'b1;
          if (send_burst > 1) begin
            send_burst--;
          end else begin
            send_burst = $urandom_range(1, 24);
            send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          op_bus.valid <= 1'b0;
        end
      end
      ready_phase = ready_phase + 4'd1;
      if (ready_phase == 0) begin
        if ($urandom_range(0, 2) == 0) ready_mask = 16'hffff;
        else ready_mask = 16'($urandom()) | (16'h1 << $urandom_range(0, 15));
      end
      res_bus.ready <= ready_mask[ready_phase];
    end
  end

  // Monitor: records each accepted word as a prediction, then scores each result word.
  always @(posedge clk_i) begin : monitor
    queue_cmd_t   seen;
    queue_reply_t want;
    if (rst_ni) begin
      if (op_bus.valid && op_bus.ready) begin
        seen.op   = op_bus.operation;
        seen.item = op_bus.item;
        seen.pos  = op_bus.position;
        expected_replies.push_back(ring_apply(seen));
        pending_ops.pop_front();
        op_pending = 1'b0;
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_replies.size() == 0) begin
          if (error_count < REPORT_MAX)
            $display("%0t: result word expected none, got status 0x%0h count 0x%0h",
                     $time, res_bus.status, res_bus.count_after);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", DW'(want.status), DW'(res_bus.status));
          check_field("count_after", DW'(want.count), DW'(res_bus.count_after));
          check_field("item_out", want.data, res_bus.item_out);
          check_field("next_position", DW'(want.next_pos), DW'(res_bus.next_position));
          check_field("reached_tail", DW'(want.at_tail), DW'(res_bus.reached_tail));
          check_field("head_position", DW'(want.head), DW'(res_bus.head_position));
          check_field("tail_position", DW'(want.tail), DW'(res_bus.tail_position));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned plan [9];
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    op_bus.valid     = 1'b0;
    op_bus.operation = rqpf_pkg::OP_APPEND;
    op_bus.item      = '0;
    op_bus.position  = '0;
    res_bus.ready    = 1'b0;
    op_pending       = 1'b0;
    error_count      = 0;
    cycle_count      = 0;
    send_gap         = 0;
    send_burst       = 1;
    ready_mask       = 16'hffff;
    ready_phase      = '0;
    ring_reset();
    plan    = '{1, 3, 127, 0, 64, 0, 5, 17, 64};
    plan[5] = $urandom_range(4, 63);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty-queue refusals, wrap of insert below slot zero, reads around the tail.
    post_op(rqpf_pkg::OP_READ, '0, 0);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);
    post_op(rqpf_pkg::OP_APPEND, 32'hffff_ffff, 0);
    post_op(rqpf_pkg::OP_APPEND, 32'h0000_0000, 63);
    post_op(rqpf_pkg::OP_INSERT, 32'ha5a5_5a5a, 0);
    post_op(rqpf_pkg::OP_READ, '0, 63);
    post_op(rqpf_pkg::OP_READ, '0, 1);
    post_op(rqpf_pkg::OP_READ, '0, 2);
    post_op(rqpf_pkg::OP_READ, '0, 62);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);
    post_op(OP_SPARE_FIRST, 32'h1234_5678, 5);
    post_op(OP_SPARE_LAST, 32'hffff_ffff, 63);
    post_op(rqpf_pkg::OP_CLEAR, '0, 0);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);

    // Full refusals on a two-slot ring and a read past the capacity.
    set_capacity(2);
    post_op(rqpf_pkg::OP_APPEND, 32'h1234_5678, 0);
    post_op(rqpf_pkg::OP_INSERT, 32'hffff_ffff, 0);
    post_op(rqpf_pkg::OP_APPEND, 32'h0bad_0bad, 0);
    post_op(rqpf_pkg::OP_INSERT, 32'h0bad_0bad, 0);
    post_op(rqpf_pkg::OP_READ, '0, 1);
    post_op(rqpf_pkg::OP_READ, '0, 0);
    post_op(rqpf_pkg::OP_READ, '0, 63);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);
    post_op(rqpf_pkg::OP_REMOVE, '0, 0);

    run_traffic(25 + ring_cap);
    foreach (plan[p]) begin
      set_capacity(plan[p]);
      run_traffic(25 + ring_cap);
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
